// File: sv/assert_macros.svh
// Assertion macros used by the light level settle filter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising clk edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/lls_pkg.sv
// Types, constants and the level function of the light level settle filter
package lls_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 17;
    localparam int LEVEL_W  = 3;
    localparam int COUNT_W  = 8;
    localparam int INDEX_W  = 3;
    localparam int BOUND_SLOTS = 16;

    localparam logic [INDEX_W-1:0] REG_CLAMP_LIMIT      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_FILTER_ENABLE    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_UP_SETTLE        = 3'd2;
    localparam logic [INDEX_W-1:0] REG_DOWN_SETTLE      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_ZERO_WATCH       = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ZERO_RUN_LIMIT   = 3'd5;
    localparam logic [INDEX_W-1:0] REG_RESET_TRY_LIMIT  = 3'd6;

    localparam logic [VALUE_W-1:0] CLAMP_LIMIT_RST     = 17'd60000;
    localparam logic               FILTER_ENABLE_RST   = 1'b1;
    localparam logic [COUNT_W-1:0] UP_SETTLE_RST       = 8'd5;
    localparam logic [COUNT_W-1:0] DOWN_SETTLE_RST     = 8'd20;
    localparam logic               ZERO_WATCH_RST      = 1'b0;
    localparam logic [COUNT_W-1:0] ZERO_RUN_LIMIT_RST  = 8'd25;
    localparam logic [COUNT_W-1:0] RESET_TRY_LIMIT_RST = 8'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic [VALUE_W-1:0] LEVEL_BOUNDS [BOUND_SLOTS] = '{
        17'd20, 17'd180, 17'd1750, 17'd17000, 17'd65000,
        17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
        17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF
    };

    typedef struct packed {
        logic [VALUE_W-1:0] clamp_limit;
        logic               level_filter_enable;
        logic [COUNT_W-1:0] up_settle;
        logic [COUNT_W-1:0] down_settle;
        logic               zero_watch_enable;
        logic [COUNT_W-1:0] zero_run_limit;
        logic [COUNT_W-1:0] reset_try_limit;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] candidate_level;
        logic [COUNT_W-1:0] settle_count;
        logic [COUNT_W-1:0] settle_target;
        logic [LEVEL_W-1:0] reported_level;
        logic [COUNT_W-1:0] zero_run;
        logic [COUNT_W-1:0] reset_tries;
    } filt_state_t;

    typedef struct packed {
        logic               report_valid;
        logic [VALUE_W-1:0] report_value;
        logic [LEVEL_W-1:0] sample_level;
        logic               sensor_reset_request;
    } result_t;

    // Count the bounds below the value among the first level_count-1 slots
    function automatic logic [LEVEL_W-1:0] level_of(
        input logic [SAMPLE_W-1:0] v,
        input int                  level_count
    );
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int i = 0; i < BOUND_SLOTS; i++)
        begin
            if ((i + 1 < level_count) && ({1'b0, v} > LEVEL_BOUNDS[i]))
            begin
                lvl = lvl + 1'b1;
            end
        end
        return lvl;
    endfunction

endpackage

// File: sv/lls_step.sv
// Per-sample clamp, level, settle filter and zero watchdog logic
module lls_step
    import lls_pkg::*;
#(
    parameter int LEVEL_COUNT = 5
)
(
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] sample,
    input  filt_state_t         state,
    output filt_state_t         state_next,
    output result_t             result
);

    logic [SAMPLE_W-1:0] v;
    logic [LEVEL_W-1:0]  lvl;
    logic                valid;
    logic                req;
    logic [COUNT_W:0]    try_cap;
    logic [COUNT_W:0]    try_inc;

    always_comb
    begin
        if ({1'b0, sample} > cfg.clamp_limit)
            v = cfg.clamp_limit[SAMPLE_W-1:0];
        else
            v = sample;
        lvl = level_of(v, LEVEL_COUNT);
    end

    always_comb
    begin
        state_next = state;
        valid      = 1'b0;
        req        = 1'b0;
        try_cap    = (cfg.reset_try_limit == COUNT_MAX) ? {1'b0, COUNT_MAX}
                                                        : {1'b0, cfg.reset_try_limit} + 1'b1;
        try_inc    = {1'b0, state.reset_tries} + 1'b1;

        if (cfg.level_filter_enable)
        begin
            if (state.candidate_level == lvl)
            begin
                if (state.settle_count >= state.settle_target)
                begin
                    valid                     = 1'b1;
                    state_next.reported_level = lvl;
                    state_next.settle_count   = '0;
                end
                else
                begin
                    state_next.settle_count = state.settle_count + 1'b1;
                end
            end
            else
            begin
                state_next.candidate_level = lvl;
                state_next.settle_count    = '0;
                state_next.settle_target   = (state.reported_level >= lvl) ? cfg.down_settle
                                                                           : cfg.up_settle;
            end
        end
        else
        begin
            valid = 1'b1;
        end

        if (cfg.zero_watch_enable && (v == '0))
        begin
            if (state.zero_run > cfg.zero_run_limit)
            begin
                state_next.zero_run    = '0;
                req                    = (state.reset_tries <= cfg.reset_try_limit);
                state_next.reset_tries = (try_inc > try_cap) ? try_cap[COUNT_W-1:0]
                                                             : try_inc[COUNT_W-1:0];
            end
            else if (state.zero_run < COUNT_MAX)
            begin
                state_next.zero_run = state.zero_run + 1'b1;
            end
        end
        else
        begin
            state_next.zero_run    = '0;
            state_next.reset_tries = '0;
        end

        result.report_valid         = valid;
        result.report_value         = valid ? ({1'b0, v} + 1'b1) : '0;
        result.sample_level         = lvl;
        result.sensor_reset_request = req;
    end

endmodule

// File: sv/light_level_settle_filter.sv
// Top level of the light level settle filter
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_stall  | sample
//   out      | out_valid / out_stall| report_valid, report_value, sample_level,
//            |                      | sensor_reset_request
//   cfg      | cfg_write            | cfg_index, cfg_data
//
// One sample per cycle sustained unless the output stalls; input, then result register.
// Work sits between the input register and the result register, with filter
// and watchdog state updated as a sample moves into the result register.
// A stalled result holds the result register; the input register keeps
// accepting while the result register is free or draining.
// Reset clears control state and loads the register defaults.
module light_level_settle_filter
    import lls_pkg::*;
#(
    parameter int LEVEL_COUNT = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                report_valid,
    output logic [VALUE_W-1:0]  report_value,
    output logic [LEVEL_W-1:0]  sample_level,
    output logic                sensor_reset_request,
    input  logic                cfg_write,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [VALUE_W-1:0]  cfg_data
);

`include "assert_macros.svh"

    cfg_t                cfg_reg;
    filt_state_t         state_reg;
    filt_state_t         state_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             result_reg;
    result_t             result_next;
    logic                advance;
    logic                in_take;

    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = s1_valid_reg && !advance;
        in_take        = in_valid && !in_stall;
        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    lls_step #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_step (
        .cfg        (cfg_reg),
        .sample     (s1_sample_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_limit         <= CLAMP_LIMIT_RST;
            cfg_reg.level_filter_enable <= FILTER_ENABLE_RST;
            cfg_reg.up_settle           <= UP_SETTLE_RST;
            cfg_reg.down_settle         <= DOWN_SETTLE_RST;
            cfg_reg.zero_watch_enable   <= ZERO_WATCH_RST;
            cfg_reg.zero_run_limit      <= ZERO_RUN_LIMIT_RST;
            cfg_reg.reset_try_limit     <= RESET_TRY_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CLAMP_LIMIT:     cfg_reg.clamp_limit         <= cfg_data;
                REG_FILTER_ENABLE:   cfg_reg.level_filter_enable <= cfg_data[0];
                REG_UP_SETTLE:       cfg_reg.up_settle           <= cfg_data[COUNT_W-1:0];
                REG_DOWN_SETTLE:     cfg_reg.down_settle         <= cfg_data[COUNT_W-1:0];
                REG_ZERO_WATCH:      cfg_reg.zero_watch_enable   <= cfg_data[0];
                REG_ZERO_RUN_LIMIT:  cfg_reg.zero_run_limit      <= cfg_data[COUNT_W-1:0];
                REG_RESET_TRY_LIMIT: cfg_reg.reset_try_limit     <= cfg_data[COUNT_W-1:0];
                default:             cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.candidate_level <= '0;
            state_reg.settle_count    <= '0;
            state_reg.settle_target   <= UP_SETTLE_RST;
            state_reg.reported_level  <= '0;
            state_reg.zero_run        <= '0;
            state_reg.reset_tries     <= '0;
            s1_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Hold payload until the next transaction moves it
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign report_valid         = result_reg.report_valid;
    assign report_value         = result_reg.report_value;
    assign sample_level         = result_reg.sample_level;
    assign sensor_reset_request = result_reg.sensor_reset_request;

    `ASSERT_CLK(a_stall_needs_item, in_stall |-> s1_valid_reg, "input stalled with empty stage")
    `ASSERT_CLK(a_request_at_zero, out_valid_reg && result_reg.sensor_reset_request |-> result_reg.sample_level == '0, "reset request on nonzero level")
    `ASSERT_CLK(a_value_when_valid, out_valid_reg && result_reg.report_valid |-> result_reg.report_value != '0, "reported value is zero")
    `ASSERT_NEVER(a_value_when_idle, out_valid_reg && !result_reg.report_valid && (result_reg.report_value != '0), "unreported value not cleared")

endmodule
